>>> rtl/cit_pkg.sv
// Shared definitions for the cascaded interval timer: operation codes,
// register selects, control bit positions and the control write merge.
// No dependencies.
package cit_pkg;

  localparam int unsigned CtlWidth  = 12;
  localparam int unsigned WordWidth = 32;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [2:0] SEL_CTRL0  = 3'd0;
  localparam logic [2:0] SEL_LOAD0  = 3'd1;
  localparam logic [2:0] SEL_COUNT0 = 3'd2;
  localparam logic [2:0] SEL_CTRL1  = 3'd3;
  localparam logic [2:0] SEL_LOAD1  = 3'd4;
  localparam logic [2:0] SEL_COUNT1 = 3'd5;

  localparam int unsigned BitCasc   = 11;
  localparam int unsigned BitStatus = 8;
  localparam int unsigned BitEnable = 7;
  localparam int unsigned BitIrqEn  = 6;
  localparam int unsigned BitLoad   = 5;
  localparam int unsigned BitAuto   = 4;
  localparam int unsigned BitDown   = 1;

  // Stores the low control bits; a 1 in the status position clears status.
  function automatic logic [CtlWidth-1:0] ctl_write(input logic [CtlWidth-1:0] old,
                                                    input logic [WordWidth-1:0] data);
    logic [CtlWidth-1:0] res;
    res = data[CtlWidth-1:0];
    res[BitStatus] = old[BitStatus] & ~data[BitStatus];
    return res;
  endfunction

endpackage

>>> rtl/cascaded_interval_timer_unit.sv
// Top level of the cascaded interval timer: input register, core, result register.
// Depends on cit_pkg and cit_core.
//
// This block is a 64-bit interval timer seen through six 32-bit registers
// (two control words, two load words, two count words). Each item is one
// clock tick, one register read or one register write, and produces exactly
// one result item carrying the read data (zero unless the item was a read)
// and the interrupt level after the item took effect. Items flow through two
// register stages: an input register, then the register-file update and
// result register, which take the item once the result register is free or
// being emptied. One item is taken every cycle as long as the result side
// keeps up; the throughput limit is the single result register. The block
// can still accept a new item while that register holds an untaken result,
// because the input register buffers one item behind it.
// Counting is always cascaded over the full 64 bits and is controlled by the
// low control word; the high control word only contributes its load bit.
// Count words are read-only.
module cascaded_interval_timer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [2:0]                     reg_select,
  input  logic [cit_pkg::WordWidth-1:0]  write_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cit_pkg::WordWidth-1:0]  read_data,
  output logic                           irq_level
);
  import cit_pkg::*;

  // Input register holding one accepted item.
  logic                 s1_valid;
  logic [1:0]           s1_op;
  logic [2:0]           s1_sel;
  logic [WordWidth-1:0] s1_data;

  logic                 s1_advance;
  logic [WordWidth-1:0] core_read_data;
  logic                 core_irq;

  // The held item moves on whenever the result register is empty or being
  // emptied in this cycle; that is also when the register file updates.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op   <= op;
      s1_sel  <= reg_select;
      s1_data <= write_data;
    end
  end

  cit_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (s1_advance),
    .op         (s1_op),
    .reg_select (s1_sel),
    .write_data (s1_data),
    .read_data  (core_read_data),
    .irq_level  (core_irq)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      read_data <= core_read_data;
      irq_level <= core_irq;
    end
  end

endmodule

>>> rtl/cit_core.sv
// Register file and counter logic of the cascaded interval timer.
// Performs one operation per enabled cycle. Depends on cit_pkg.
module cit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step_en,
  input  logic [1:0]                     op,
  input  logic [2:0]                     reg_select,
  input  logic [cit_pkg::WordWidth-1:0]  write_data,
  output logic [cit_pkg::WordWidth-1:0]  read_data,
  output logic                           irq_level
);
  import cit_pkg::*;

  logic [CtlWidth-1:0]  control_lo, control_lo_next;
  logic [CtlWidth-1:0]  control_hi, control_hi_next;
  logic [WordWidth-1:0] reload_lo, reload_lo_next;
  logic [WordWidth-1:0] reload_hi, reload_hi_next;
  logic [WordWidth-1:0] count_lo, count_lo_next;
  logic [WordWidth-1:0] count_hi, count_hi_next;

  logic [2*WordWidth-1:0] value, value_next;

  assign value = {count_hi, count_lo};

  always_comb begin
    control_lo_next = control_lo;
    control_hi_next = control_hi;
    reload_lo_next  = reload_lo;
    reload_hi_next  = reload_hi;
    count_lo_next   = count_lo;
    count_hi_next   = count_hi;
    value_next      = value;
    read_data       = '0;
    case (op_t'(op))
      OP_TICK: begin
        if (control_lo[BitLoad] || control_hi[BitLoad]) begin
          if (control_lo[BitLoad]) count_lo_next = reload_lo;
          if (control_hi[BitLoad]) count_hi_next = reload_hi;
        end else if (control_lo[BitEnable]) begin
          if (control_lo[BitDown]) begin
            if (value == '0) begin
              control_lo_next[BitStatus] = 1'b1;
              if (control_lo[BitAuto]) value_next = {reload_hi, reload_lo};
            end else begin
              value_next = value - 64'd1;
            end
          end else begin
            value_next = value + 64'd1;
          end
          count_lo_next = value_next[WordWidth-1:0];
          count_hi_next = value_next[2*WordWidth-1:WordWidth];
        end
      end
      OP_READ: begin
        unique case (reg_select)
          SEL_CTRL0:  read_data = {{(WordWidth-CtlWidth){1'b0}}, control_lo};
          SEL_LOAD0:  read_data = reload_lo;
          SEL_COUNT0: read_data = count_lo;
          SEL_CTRL1:  read_data = {{(WordWidth-CtlWidth){1'b0}}, control_hi};
          SEL_LOAD1:  read_data = reload_hi;
          SEL_COUNT1: read_data = count_hi;
          default:    read_data = '0;
        endcase
      end
      OP_WRITE: begin
        // Count words are read-only; writes to them are dropped.
        unique case (reg_select)
          SEL_CTRL0: control_lo_next = ctl_write(control_lo, write_data);
          SEL_LOAD0: reload_lo_next  = write_data;
          SEL_CTRL1: control_hi_next = ctl_write(control_hi, write_data);
          SEL_LOAD1: reload_hi_next  = write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign irq_level = control_lo_next[BitStatus] & control_lo_next[BitIrqEn];

  always_ff @(posedge clk) begin
    if (rst) begin
      control_lo <= '0;
      control_hi <= '0;
      reload_lo  <= '0;
      reload_hi  <= '0;
      count_lo   <= '0;
      count_hi   <= '0;
    end else if (step_en) begin
      control_lo <= control_lo_next;
      control_hi <= control_hi_next;
      reload_lo  <= reload_lo_next;
      reload_hi  <= reload_hi_next;
      count_lo   <= count_lo_next;
      count_hi   <= count_hi_next;
    end
  end

endmodule

>>> rtl/cit_checker.sv
// Port-level checker for cascaded_interval_timer_unit and its bind statement.
// Depends on the top level's port list only.
module cit_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic        irq_level
);

  // A result waiting to be taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_level))
    else $error("result changed while stalled");

  // Nothing is presented right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the block always takes a new item.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // An accepted item reaches the output in the cycle after the output frees up.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind cascaded_interval_timer_unit cit_checker u_cit_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_data (read_data),
  .irq_level (irq_level)
);
